@@ hdl/ace_pkg.sv @@
package ace_pkg;

   // Field widths.
   localparam int SAMPLE_W = 16;
   localparam int CHAN_W   = 3;
   localparam int TICK_W   = 32;
   localparam int PHASE_W  = 2;
   localparam int RATIO_W  = 15;
   localparam int TIME_W   = 21;
   localparam int CSR_W    = 21;
   localparam int CSR_IDX_W = 2;

   // Default channel count.
   localparam int CHANNELS_DEF = 8;

   // Internal arithmetic widths.
   localparam int DIFF_W   = SAMPLE_W + 1;     // sample minus threshold
   localparam int DELTA_W  = 24;               // magnitude of the reduction
   localparam int PROD_W   = DELTA_W + TIME_W; // reduction times elapsed ticks
   localparam int DIV_NUM_W = 46;              // dividend and quotient register
   localparam int DIV_DEN_W = TIME_W;          // divisor
   localparam int DIV_CNT_W = 5;               // count of double steps
   localparam int OUT_W    = DELTA_W + 2;      // sample minus signed reduction

   // Double-step counts for the two divisions.
   localparam logic [DIV_CNT_W-1:0] DIV1_STEPS = DIV_CNT_W'(DELTA_W / 2);
   localparam logic [DIV_CNT_W-1:0] DIV2_STEPS = DIV_CNT_W'(DIV_NUM_W / 2);

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RATIO     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ATTACK    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RELEASE   = 2'd3;

   // Register reset values.
   localparam logic signed [SAMPLE_W-1:0] THRESHOLD_RST = 16'sd16384;
   localparam logic [RATIO_W-1:0]         RATIO_RST     = 15'd1024;
   localparam logic [TIME_W-1:0]          ATTACK_RST    = 21'd441;
   localparam logic [TIME_W-1:0]          RELEASE_RST   = 21'd4410;

   // Channel phases.
   localparam logic [PHASE_W-1:0] PH_HOLD    = 2'd0;
   localparam logic [PHASE_W-1:0] PH_ATTACK  = 2'd1;
   localparam logic [PHASE_W-1:0] PH_ACTIVE  = 2'd2;
   localparam logic [PHASE_W-1:0] PH_RELEASE = 2'd3;

   // How the output is formed.
   localparam logic [1:0] MODE_PASS   = 2'd0;
   localparam logic [1:0] MODE_TARGET = 2'd1;
   localparam logic [1:0] MODE_RAMP   = 2'd2;

   // One row of per-channel state.
   typedef struct packed {
      logic [PHASE_W-1:0] phase;
      logic [TICK_W-1:0]  tick;
   } ace_row_type;

   // Request to the shared divider.
   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] dividend;
      logic [DIV_DEN_W-1:0] divisor;
      logic [DIV_CNT_W-1:0] half_steps;
   } ace_div_req_type;

   // Divider status and result.
   typedef struct packed {
      logic                 done;
      logic [DIV_NUM_W-1:0] quotient;
   } ace_div_rsp_type;

endpackage

@@ hdl/ace_state_mem.sv @@
module ace_state_mem
   import ace_pkg::*;
#(
   parameter int CHANNELS = CHANNELS_DEF,
   parameter int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        rd_en,
   input  logic [CH_W-1:0] rd_addr,
   output ace_row_type rd_data,
   input  logic        wr_en,
   input  logic [CH_W-1:0] wr_addr,
   input  ace_row_type wr_data
);

   ace_row_type         mem [CHANNELS];
   logic [CHANNELS-1:0] valid_ff;
   ace_row_type         data_ff;
   logic                rd_valid_ff;

   // Per-channel valid bits: a channel never written reads as hold at tick zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // Row storage with a registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else if (rd_en) begin
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? data_ff : '0;

endmodule

@@ hdl/ace_divider.sv @@
module ace_divider
   import ace_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  ace_div_req_type div_req,
   output ace_div_rsp_type div_rsp
);

   logic [DIV_NUM_W-1:0] num_ff, num_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;

   // Two restoring division steps per cycle while busy; quotient bits shift in at the bottom.
   always_comb begin
      logic [DIV_DEN_W:0] trial;
      num_in = num_ff;
      rem_in = rem_ff;
      trial  = '0;
      for (int i = 0; i < 2; i++) begin
         trial  = {rem_in, num_in[DIV_NUM_W-1]};
         num_in = {num_in[DIV_NUM_W-2:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            rem_in    = DIV_DEN_W'(trial - {1'b0, den_ff});
            num_in[0] = 1'b1;
         end else begin
            rem_in = trial[DIV_DEN_W-1:0];
         end
      end
   end

   // Step counter and completion pulse.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= div_req.half_steps;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == DIV_CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Operand registers.
   always_ff @(posedge clock) begin
      if (div_req.start) begin
         num_ff <= div_req.dividend;
         rem_ff <= '0;
         den_ff <= div_req.divisor;
      end else if (busy_ff) begin
         num_ff <= num_in;
         rem_ff <= rem_in;
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = num_ff;

endmodule

@@ hdl/audio_compressor_envelope.sv @@
// Per-channel downward compressor with linear attack and release ramps.
// Input beats (req_*) carry a channel number, a signed sample and a tick
// stamp; each accepted beat yields exactly one result beat (rsp_*) with the
// compressed sample and the channel's phase after the update. Both channels
// use valid/ready handshakes. Registers are written through csr_we,
// csr_index and csr_wdata; the user must write them only while the block is
// idle, which the block itself does not enforce. A passed sample goes from
// the load state straight to the output state; with the full reduction the
// item first waits on the reduction division, and on an attack or release
// ramp also on a multiply step and the ramp scaling division, both divisions
// running on the shared radix-4 divider. The sequencer returns to idle, ready
// for the next beat, as the result moves into the output register. One item
// is computed at a time; req_ready is high only while the sequencer is idle.
// When rsp_ready is low the result beat holds in the output register; the
// next item is still computed but then waits in the sequencer with req_ready
// low, and its channel state is written only when it moves to the output
// register. Reset restores the register defaults and puts every channel in
// hold at tick zero; the channel store is ready right after reset.
module audio_compressor_envelope
   import ace_pkg::*;
#(
   parameter int CHANNELS = CHANNELS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [CHAN_W-1:0]          req_channel,
   input  logic signed [SAMPLE_W-1:0] req_sample_in,
   input  logic [TICK_W-1:0]          req_time_ticks,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [SAMPLE_W-1:0] rsp_sample_out,
   output logic [PHASE_W-1:0]         rsp_phase_out,
   input  logic                       csr_we,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_W-1:0]           csr_wdata
);

   localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_LOAD  = 3'd1;
   localparam logic [2:0] S_DIV1  = 3'd2;
   localparam logic [2:0] S_MUL   = 3'd3;
   localparam logic [2:0] S_DIV2S = 3'd4;
   localparam logic [2:0] S_DIV2  = 3'd5;
   localparam logic [2:0] S_OUT   = 3'd6;

   // Configuration.
   logic signed [SAMPLE_W-1:0] thr_ff;
   logic [RATIO_W-1:0]         ratio_ff;
   logic [TIME_W-1:0]          atk_ff;
   logic [TIME_W-1:0]          rel_ff;

   // Sequencer and item registers.
   logic [2:0]                 state_ff, state_in;
   logic [CHAN_W-1:0]          ch_ff;
   logic signed [SAMPLE_W-1:0] x_ff;
   logic [TICK_W-1:0]          now_ff;
   logic signed [DIFF_W-1:0]   d_ff;
   logic                       oor_ff;
   logic [PHASE_W-1:0]         ph_ff, ph_in;
   logic [1:0]                 mode_ff, mode_in;
   logic                       upd_ff, upd_in;
   logic [TIME_W-1:0]          mult_ff, mult_in;
   logic [TIME_W-1:0]          rdiv_ff, rdiv_in;
   logic [DELTA_W-1:0]         delta_ff;
   logic [PROD_W-1:0]          prod_ff;
   logic                       rsp_valid_ff;
   logic signed [SAMPLE_W-1:0] rsp_sample_ff;
   logic [PHASE_W-1:0]         rsp_phase_ff;

   logic                       accept;
   logic                       out_fire;
   ace_row_type                row;
   ace_row_type                wr_row;
   ace_div_req_type            div_req;
   ace_div_rsp_type            div_rsp;
   logic [TICK_W-1:0]          elapsed;
   logic                       x_ge, x_gt;
   logic [DIFF_W-1:0]          d_mag;
   logic [DIV_DEN_W-1:0]       ratio_div;
   logic signed [OUT_W-1:0]    y_wide;
   logic signed [OUT_W-1:0]    red_signed;
   logic signed [SAMPLE_W-1:0] y_sat;

   assign accept   = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign out_fire = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_ready);

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff   <= THRESHOLD_RST;
         ratio_ff <= RATIO_RST;
         atk_ff   <= ATTACK_RST;
         rel_ff   <= RELEASE_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_THRESHOLD: thr_ff   <= csr_wdata[SAMPLE_W-1:0];
            CSR_RATIO:     ratio_ff <= csr_wdata[RATIO_W-1:0];
            CSR_ATTACK:    atk_ff   <= csr_wdata[TIME_W-1:0];
            CSR_RELEASE:   rel_ff   <= csr_wdata[TIME_W-1:0];
            default: ;
         endcase
      end
   end

   // Per-channel state store.
   assign wr_row.phase = ph_ff;
   assign wr_row.tick  = upd_ff ? now_ff : row.tick;

   ace_state_mem #(
      .CHANNELS (CHANNELS),
      .CH_W     (CH_W)
   ) u_state_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (CH_W'(req_channel)),
      .rd_data (row),
      .wr_en   (out_fire && !oor_ff),
      .wr_addr (CH_W'(ch_ff)),
      .wr_data (wr_row)
   );

   // Phase decision once the channel row is available.
   assign elapsed = now_ff - row.tick;
   assign x_ge    = !d_ff[DIFF_W-1];
   assign x_gt    = x_ge && (d_ff != '0);

   always_comb begin
      ph_in   = row.phase;
      mode_in = MODE_PASS;
      upd_in  = 1'b0;
      mult_in = elapsed[TIME_W-1:0];
      rdiv_in = atk_ff;
      if (oor_ff) begin
         ph_in = PH_HOLD;
      end else begin
         case (row.phase)
            PH_HOLD: begin
               if (x_ge) begin
                  ph_in  = PH_ATTACK;
                  upd_in = 1'b1;
               end
            end
            PH_ATTACK: begin
               if (!x_ge) begin
                  ph_in  = PH_RELEASE;
                  upd_in = 1'b1;
               end else if (elapsed < TICK_W'(atk_ff)) begin
                  mode_in = MODE_RAMP;
               end else begin
                  mode_in = MODE_TARGET;
                  ph_in   = PH_ACTIVE;
               end
            end
            PH_ACTIVE: begin
               if (x_gt) begin
                  mode_in = MODE_TARGET;
               end else begin
                  ph_in  = PH_RELEASE;
                  upd_in = 1'b1;
               end
            end
            default: begin
               if (x_gt) begin
                  ph_in  = PH_ATTACK;
                  upd_in = 1'b1;
               end else if (elapsed < TICK_W'(rel_ff)) begin
                  mode_in = MODE_RAMP;
                  mult_in = rel_ff - elapsed[TIME_W-1:0];
                  rdiv_in = rel_ff;
               end else begin
                  ph_in = PH_HOLD;
               end
            end
         endcase
      end
   end

   // Divider requests: first the reduction, then the ramp scaling.
   assign d_mag     = d_ff[DIFF_W-1] ? DIFF_W'(-d_ff) : DIFF_W'(d_ff);
   assign ratio_div = (ratio_ff == '0) ? DIV_DEN_W'(1) : DIV_DEN_W'(ratio_ff);

   always_comb begin
      div_req = '0;
      if (state_ff == S_LOAD) begin
         div_req.start      = (mode_in != MODE_PASS);
         div_req.dividend   = {d_mag[SAMPLE_W-1:0], 8'b0,
                               (DIV_NUM_W - DELTA_W)'(0)};
         div_req.divisor    = ratio_div;
         div_req.half_steps = DIV1_STEPS;
      end else if (state_ff == S_DIV2S) begin
         div_req.start      = 1'b1;
         div_req.dividend   = DIV_NUM_W'(prod_ff);
         div_req.divisor    = rdiv_ff;
         div_req.half_steps = DIV2_STEPS;
      end
   end

   ace_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Output value: the sample minus the signed reduction, saturated.
   always_comb begin
      if (mode_ff == MODE_PASS) begin
         red_signed = '0;
      end else if (d_ff[DIFF_W-1]) begin
         red_signed = -OUT_W'(delta_ff);
      end else begin
         red_signed = OUT_W'(delta_ff);
      end
      y_wide = OUT_W'(x_ff) - red_signed;
      if (y_wide > OUT_W'(32767)) begin
         y_sat = 16'sh7fff;
      end else if (y_wide < -OUT_W'(32768)) begin
         y_sat = 16'sh8000;
      end else begin
         y_sat = y_wide[SAMPLE_W-1:0];
      end
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (accept) state_in = S_LOAD;
         S_LOAD:  state_in = (mode_in == MODE_PASS) ? S_OUT : S_DIV1;
         S_DIV1: begin
            if (div_rsp.done) begin
               state_in = (mode_ff == MODE_RAMP) ? S_MUL : S_OUT;
            end
         end
         S_MUL:   state_in = S_DIV2S;
         S_DIV2S: state_in = S_DIV2;
         S_DIV2:  if (div_rsp.done) state_in = S_OUT;
         S_OUT:   if (out_fire) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Item and working registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         ch_ff  <= req_channel;
         x_ff   <= req_sample_in;
         now_ff <= req_time_ticks;
         d_ff   <= DIFF_W'(req_sample_in) - DIFF_W'(thr_ff);
         oor_ff <= (32'(req_channel) >= CHANNELS);
      end
      if (state_ff == S_LOAD) begin
         ph_ff   <= ph_in;
         mode_ff <= mode_in;
         upd_ff  <= upd_in;
         mult_ff <= mult_in;
         rdiv_ff <= rdiv_in;
      end
      if ((state_ff == S_DIV1 || state_ff == S_DIV2) && div_rsp.done) begin
         delta_ff <= div_rsp.quotient[DELTA_W-1:0];
      end
      if (state_ff == S_MUL) begin
         prod_ff <= PROD_W'(delta_ff) * PROD_W'(mult_ff);
      end
   end

   // Result beat register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_fire) begin
         rsp_sample_ff <= y_sat;
         rsp_phase_ff  <= ph_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;
   assign rsp_phase_out  = rsp_phase_ff;

endmodule
